[rtl/core/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned OccW         = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic                    valid;
    status_e                 status;
    logic signed [DataW-1:0] removed;
    logic [OccW-1:0]         occ;
  } res_t;

endpackage

[rtl/core/spq_ram.sv]
// Entry store: one write port and one registered read port.
module spq_ram #(
  parameter int unsigned Depth = spq_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [spq_pkg::DataW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [spq_pkg::DataW-1:0] rdata_o
);
  import spq_pkg::*;

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/spq_seq.sv]
// Sequencer that shifts entries through the store one at a time using a single comparator.
module spq_seq #(
  parameter int unsigned Depth = spq_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(Depth),
  parameter int unsigned CW    = $clog2(Depth + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            action_i,
  input  logic signed [spq_pkg::DataW-1:0] value_i,
  output logic                            busy,
  output logic                            we_o,
  output logic [AW-1:0]                   waddr_o,
  output logic [spq_pkg::DataW-1:0]        wdata_o,
  output logic                            re_o,
  output logic [AW-1:0]                   raddr_o,
  input  logic [spq_pkg::DataW-1:0]        rdata_i,
  output spq_pkg::res_t                   res_o
);
  import spq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_INS_CMP   = 5'b00010,
    S_INS_LAST  = 5'b00100,
    S_DEL_HEAD  = 5'b01000,
    S_DEL_SHIFT = 5'b10000
  } state_e;

  localparam logic [CW-1:0] DepthC = CW'(Depth);
  localparam logic [CW-1:0] OneC   = CW'(1);

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic signed [DataW-1:0] value_q;
  logic [DataW-1:0]        removed_q, removed_d;
  logic                    accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    removed_d = removed_q;
    we_o      = 1'b0;
    waddr_o   = '0;
    wdata_o   = '0;
    re_o      = 1'b0;
    raddr_o   = '0;
    res_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (action_i == ACT_DELETE) begin
            if (count_q == '0) begin
              res_o.valid  = 1'b1;
              res_o.status = ST_EMPTY;
            end else begin
              re_o    = 1'b1;
              raddr_o = '0;
              state_d = S_DEL_HEAD;
            end
          end else begin
            if (count_q >= DepthC) begin
              res_o.valid  = 1'b1;
              res_o.status = ST_FULL;
              res_o.occ    = OccW'(count_q);
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = S_INS_LAST;
            end else begin
              idx_d   = count_q;
              re_o    = 1'b1;
              raddr_o = AW'(count_q - OneC);
              state_d = S_INS_CMP;
            end
          end
        end
      end
      S_INS_CMP: begin
        // The entry below the hole is larger: move it up and keep walking down.
        if ($signed(rdata_i) > value_q) begin
          we_o    = 1'b1;
          waddr_o = AW'(idx_q);
          wdata_o = rdata_i;
          idx_d   = idx_q - OneC;
          if (idx_q == OneC) begin
            state_d = S_INS_LAST;
          end else begin
            re_o    = 1'b1;
            raddr_o = AW'(idx_q - CW'(2));
          end
        end else begin
          we_o         = 1'b1;
          waddr_o      = AW'(idx_q);
          wdata_o      = value_q;
          count_d      = count_q + OneC;
          res_o.valid  = 1'b1;
          res_o.status = ST_OK;
          res_o.occ    = OccW'(count_q + OneC);
          state_d      = S_IDLE;
        end
      end
      S_INS_LAST: begin
        we_o         = 1'b1;
        waddr_o      = AW'(idx_q);
        wdata_o      = value_q;
        count_d      = count_q + OneC;
        res_o.valid  = 1'b1;
        res_o.status = ST_OK;
        res_o.occ    = OccW'(count_q + OneC);
        state_d      = S_IDLE;
      end
      S_DEL_HEAD: begin
        removed_d = rdata_i;
        if (count_q == OneC) begin
          count_d       = count_q - OneC;
          res_o.valid   = 1'b1;
          res_o.status  = ST_OK;
          res_o.removed = rdata_i;
          res_o.occ     = OccW'(count_q - OneC);
          state_d       = S_IDLE;
        end else begin
          idx_d   = OneC;
          re_o    = 1'b1;
          raddr_o = AW'(1);
          state_d = S_DEL_SHIFT;
        end
      end
      S_DEL_SHIFT: begin
        we_o    = 1'b1;
        waddr_o = AW'(idx_q - OneC);
        wdata_o = rdata_i;
        if ((idx_q + OneC) == count_q) begin
          count_d       = count_q - OneC;
          res_o.valid   = 1'b1;
          res_o.status  = ST_OK;
          res_o.removed = removed_q;
          res_o.occ     = OccW'(count_q - OneC);
          state_d       = S_IDLE;
        end else begin
          re_o    = 1'b1;
          raddr_o = AW'(idx_q + OneC);
          idx_d   = idx_q + OneC;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    removed_q <= removed_d;
    if (accept) begin
      value_q <= value_i;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> (state_q != S_IDLE))
    else $error("store written while idle");

  a_cmp_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CMP) |-> (idx_q != '0) && (count_q < DepthC))
    else $error("insert walk out of range");

  a_count_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(res_o.valid))
    else $error("count changed without a result");

endmodule

[rtl/core/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: sequencer, entry store and result register.
// An insert moves each larger entry up one place, then writes the new value; a refusal leaves the store alone.
// A delete reads the head, then shifts every remaining entry down one place through the store's one read port.
// busy is high while an operation runs; the receiver cannot stall the result strobe.
// Reset clears the count and the control state; the store contents stay undefined.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic signed [spq_pkg::DataW-1:0]    value_i,
  output logic                                done_o,
  output logic [spq_pkg::StatusW-1:0]         status_o,
  output logic signed [spq_pkg::DataW-1:0]    removed_value_o,
  output logic [spq_pkg::OccW-1:0]            occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [DataW-1:0] rdata;
  res_t             res;
  logic             done_q;
  res_t             res_q;

  spq_seq #(
    .Depth (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .value_i  (value_i),
    .busy     (busy),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .re_o     (re),
    .raddr_o  (raddr),
    .rdata_i  (rdata),
    .res_o    (res)
  );

  spq_ram #(
    .Depth (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // The result beat is held for exactly one cycle after the operation finishes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      res_q <= res;
    end
  end

  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign removed_value_o = res_q.removed;
  assign occupancy_o     = res_q.occ;

endmodule

[sim/tb.sv]
// Self-checking testbench for the sorted priority queue: random and directed operations.
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ITEM_TOTAL = 1350;
  localparam int unsigned CYCLE_CAP  = 200000;

  typedef struct {
    action_e                 act;
    logic signed [DataW-1:0] val;
  } op_t;

  typedef struct {
    status_e                 status;
    logic signed [DataW-1:0] removed;
    logic [OccW-1:0]         occ;
  } outcome_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic                      action_i;
  logic signed [DataW-1:0]   value_i;
  logic                      done_o;
  logic [StatusW-1:0]        status_o;
  logic signed [DataW-1:0]   removed_value_o;
  logic [OccW-1:0]           occupancy_o;

  op_t                       pending_ops[$];
  outcome_t                  awaiting_results[$];
  logic signed [DataW-1:0]   held_values[$];
  logic                      beat_taken;
  int unsigned               sent_cnt;
  int unsigned               taken_cnt;
  int unsigned               fail_cnt;
  int unsigned               cycle_cnt;

  sorted_priority_queue_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result of one operation and updates the sorted copy of the store.
  function automatic outcome_t predict_step(action_e act, logic signed [DataW-1:0] val);
    outcome_t    res;
    int unsigned pos;
    res.status  = ST_OK;
    res.removed = '0;
    if (act == ACT_INSERT) begin
      if (held_values.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // A new value goes behind every equal value already held.
        pos = 0;
        while (pos < held_values.size() && held_values[pos] <= val) pos++;
        held_values.insert(pos, val);
      end
    end else begin
      if (held_values.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed = held_values.pop_front();
      end
    end
    res.occ = OccW'(held_values.size());
    return res;
  endfunction

  function automatic logic signed [DataW-1:0] pick_word();
    logic signed [DataW-1:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2: w = $signed($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0:       w = 32'sh7FFF_FFFF;
          1:       w = 32'sh8000_0000;
          2:       w = -1;
          default: w = 0;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic queue_op(action_e act, logic signed [DataW-1:0] val);
    op_t op;
    op.act = act;
    op.val = val;
    pending_ops.push_back(op);
  endtask

  // Driver: a new beat is offered once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || beat_taken)) begin
      if (pending_ops.size() != 0 &&
          !((sent_cnt < 400 || sent_cnt >= 800) && $urandom_range(0, 99) < 6)) begin
        start    <= 1'b1;
        action_i <= pending_ops[0].act;
        value_i  <= pending_ops[0].val;
        void'(pending_ops.pop_front());
        sent_cnt <= sent_cnt + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks the result strobe, then records any beat accepted at this edge.
  always @(posedge clk_i) begin
    outcome_t want;
    beat_taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (done_o) begin
        if (awaiting_results.size() == 0) begin
          $error("unexpected result: status %0d removed_value %0d occupancy %0d",
                 status_o, removed_value_o, occupancy_o);
          fail_cnt++;
        end else begin
          want = awaiting_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fail_cnt++;
          end
          if (removed_value_o !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed, removed_value_o);
            fail_cnt++;
          end
          if (occupancy_o !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        awaiting_results.push_back(predict_step(action_e'(action_i), value_i));
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned burst;
    int unsigned insert_pct;
    logic signed [DataW-1:0] fill_vals[16];
    start      = 1'b0;
    action_i   = ACT_INSERT;
    value_i    = '0;
    beat_taken = 1'b0;
    sent_cnt   = 0;
    taken_cnt  = 0;
    fail_cnt   = 0;
    cycle_cnt  = 0;
    rst_ni     = 1'b0;

    // Delete from an empty store, fill it with extremes and repeats, overfill, drain part.
    fill_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 5, 5, 5,
                  -5, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 7, 7, -100, 1000};
    queue_op(ACT_DELETE, 32'sh5A5A_5A5A);
    foreach (fill_vals[k]) queue_op(ACT_INSERT, fill_vals[k]);
    queue_op(ACT_INSERT, 3);
    repeat (7) queue_op(ACT_DELETE, pick_word());

    // Bursts leaning towards insert or delete so the store swings between full and empty.
    while (pending_ops.size() < ITEM_TOTAL) begin
      burst = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 25;
        1:       insert_pct = 50;
        default: insert_pct = 80;
      endcase
      repeat (burst) begin
        if ($urandom_range(0, 99) < insert_pct) queue_op(ACT_INSERT, pick_word());
        else queue_op(ACT_DELETE, pick_word());
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_cnt < ITEM_TOTAL + 25 + 60 && (pending_ops.size() != 0 || start))
      @(posedge clk_i);
    while (awaiting_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_seq.sv
rtl/core/sorted_priority_queue_top.sv
sim/tb.sv
